// ----- src/cubic_curve_segment_evaluator_core_assert.svh -----
// Assertion macros for the cubic curve segment evaluator core.
`ifndef CUBIC_CURVE_SEGMENT_EVALUATOR_CORE_ASSERT_SVH
`define CUBIC_CURVE_SEGMENT_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ccse_pkg.sv -----
// Shared types, constants and the basis coefficient function of the curve evaluator.
`default_nettype none

package ccse_pkg;

  typedef enum logic [1:0] {
    KIND_LINEAR  = 2'd0,
    KIND_CATROM  = 2'd1,
    KIND_BSPLINE = 2'd2,
    KIND_BEZIER  = 2'd3
  } kind_e;

  // parameter t, unsigned Q1.16
  localparam int unsigned T_W   = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h1_0000;
  // t squared and t cubed widths
  localparam int unsigned T2_W  = 33;
  localparam int unsigned T3_W  = 49;
  localparam int unsigned P3_W  = 41;

  // basis coefficients, signed Q.12
  localparam int unsigned COEF_W = 19;
  typedef logic signed [COEF_W-1:0] coef_t;

  // weight sum (Q.52) and weight (Q.20)
  localparam int unsigned WSUM_W = 60;
  localparam int unsigned WGT_W  = 28;
  typedef logic signed [WGT_W-1:0] weight_t;

  // control values and result, signed Q16.16
  typedef logic signed [31:0] point_t;

  localparam int unsigned BASIS_LAT  = 6;
  localparam int unsigned DOT_LAT    = 4;
  localparam int unsigned PIPE_DEPTH = BASIS_LAT + DOT_LAT;

  // rounding offsets placed below the constant term of a weight sum
  localparam logic [39:0] RND_PLAIN = 40'h00_8000_0000;
  localparam logic [39:0] RND_BSPL  = 40'h03_0000_0000;

  // floor division by three through a reciprocal, biased to stay non-negative
  localparam logic [31:0] BSPL_OFS  = 32'h3000_0000;
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [30:0] BSPL_BIAS = 31'h1000_0000;

  localparam logic [15:0] TENSION_RST = 16'h0800;

  localparam coef_t K1 = 19'sd4096;
  localparam coef_t K2 = 19'sd8192;
  localparam coef_t K3 = 19'sd12288;

  // fixed basis rows in units of one: [kind][derivative][control][power]
  localparam logic signed [4:0] BASIS_TAB [4][2][4][4] = '{
    '{ '{ '{ 5'sd1, -5'sd1,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd1,  5'sd0,  5'sd0},
          '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0} },
       '{ '{-5'sd1,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd1,  5'sd0,  5'sd0,  5'sd0},
          '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0} } },
    '{ '{ '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0},
          '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0} },
       '{ '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0},
          '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0} } },
    '{ '{ '{ 5'sd1, -5'sd3,  5'sd3, -5'sd1}, '{ 5'sd4,  5'sd0, -5'sd6,  5'sd3},
          '{ 5'sd1,  5'sd3,  5'sd3, -5'sd3}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd1} },
       '{ '{-5'sd3,  5'sd6, -5'sd3,  5'sd0}, '{ 5'sd0, -5'sd12, 5'sd9,  5'sd0},
          '{ 5'sd3,  5'sd6, -5'sd9,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd3,  5'sd0} } },
    '{ '{ '{ 5'sd1, -5'sd3,  5'sd3, -5'sd1}, '{ 5'sd0,  5'sd3, -5'sd6,  5'sd3},
          '{ 5'sd0,  5'sd0,  5'sd3, -5'sd3}, '{ 5'sd0,  5'sd0,  5'sd0,  5'sd1} },
       '{ '{-5'sd3,  5'sd6, -5'sd3,  5'sd0}, '{ 5'sd3, -5'sd12, 5'sd9,  5'sd0},
          '{ 5'sd0,  5'sd6, -5'sd9,  5'sd0}, '{ 5'sd0,  5'sd0,  5'sd3,  5'sd0} } }
  };

  // coefficient of power k of t in the weight of control value i
  function automatic coef_t coef_f(kind_e kind, logic der, logic signed [15:0] tension,
                                   logic [1:0] i, logic [1:0] k);
    coef_t s;
    coef_t r0;
    coef_t r1;
    coef_t r2;
    coef_t r3;
    coef_t res;
    s  = coef_t'(tension);
    r0 = '0;
    r1 = '0;
    r2 = '0;
    r3 = '0;
    res = '0;
    if (kind == KIND_CATROM) begin
      if (!der) begin
        case (i)
          2'd0: begin r1 = -s;      r2 = s + s;           r3 = -s;      end
          2'd1: begin r0 = K1;      r2 = s - K3;          r3 = K2 - s;  end
          2'd2: begin r1 = s;       r2 = K3 - s - s;      r3 = s - K2;  end
          default: begin r2 = -s;   r3 = s;                             end
        endcase
      end else begin
        case (i)
          2'd0: begin r0 = -s;  r1 = s <<< 2;              r2 = -(s + s + s);      end
          2'd1: begin r1 = (s - K3) <<< 1;                 r2 = K3 + K3 - s - s - s; end
          2'd2: begin r0 = s;   r1 = (K3 - s - s) <<< 1;   r2 = s + s + s - K3 - K3; end
          default: begin r1 = -(s + s);                    r2 = s + s + s;         end
        endcase
      end
      case (k)
        2'd0:    res = r0;
        2'd1:    res = r1;
        2'd2:    res = r2;
        default: res = r3;
      endcase
    end else begin
      res = coef_t'(BASIS_TAB[kind][der][i][k]) <<< 12;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/ccse_basis.sv -----
// Six-stage pipeline that forms the four basis weights from t, kind and tension.
`default_nettype none

module ccse_basis import ccse_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  kind_e               kind_i,
  input  logic                der_i,
  input  logic [T_W-1:0]      t_frac_i,
  input  logic signed [15:0]  tension_i,
  output weight_t             weight_o [4]
);

  // stage 1: clamp t, square it, pick coefficients
  logic [T_W-1:0]     t_clamp;
  logic [2*T_W-1:0]   t_sq_full;
  coef_t              coef_d [4][4];
  logic [T_W-1:0]     t1_q;
  logic [T2_W-1:0]    t2_q;
  coef_t              c1_q [4][4];
  logic               bsp1_q;

  assign t_clamp   = (t_frac_i > T_ONE) ? T_ONE : t_frac_i;
  assign t_sq_full = t_clamp * t_clamp;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        coef_d[i][k] = coef_f(kind_i, der_i, tension_i, 2'(i), 2'(k));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_clamp;
      t2_q   <= t_sq_full[T2_W-1:0];
      bsp1_q <= (kind_i == KIND_BSPLINE);
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          c1_q[i][k] <= coef_d[i][k];
        end
      end
    end
  end

  // stage 2: cube t, multiply the linear and square terms
  logic [T2_W+T_W-1:0]          t3_full;
  logic signed [COEF_W+T_W:0]   m1 [4];
  logic signed [COEF_W+T2_W:0]  m2 [4];
  logic [T3_W-1:0]              t3_q;
  logic signed [COEF_W+T_W:0]   m1_q [4];
  logic signed [COEF_W+T2_W:0]  m2_q [4];
  coef_t                        c0_q [4];
  coef_t                        c3_q [4];
  logic                         bsp2_q;

  assign t3_full = t2_q * t1_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m1[i] = c1_q[i][1] * $signed({1'b0, t1_q});
      m2[i] = c1_q[i][2] * $signed({1'b0, t2_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_q   <= t3_full[T3_W-1:0];
      bsp2_q <= bsp1_q;
      for (int i = 0; i < 4; i++) begin
        m1_q[i] <= m1[i];
        m2_q[i] <= m2[i];
        c0_q[i] <= c1_q[i][0];
        c3_q[i] <= c1_q[i][3];
      end
    end
  end

  // stage 3: round the cube, multiply it, add the other three terms
  logic [T3_W-1:0]              p3_sum;
  logic [P3_W-1:0]              p3;
  logic signed [COEF_W+P3_W:0]  m3 [4];
  logic [39:0]                  rnd;
  logic [WSUM_W-1:0]            s_d [4];
  logic [WSUM_W-1:0]            s_q [4];
  logic [WSUM_W-1:0]            m3_q [4];
  logic                         bsp3_q;

  assign p3_sum = t3_q + T3_W'(128);
  assign p3     = p3_sum[T3_W-1:8];
  assign rnd    = bsp2_q ? RND_BSPL : RND_PLAIN;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m3[i]  = c3_q[i] * $signed({1'b0, p3});
      s_d[i] = {c0_q[i][COEF_W-1], c0_q[i], rnd}
             + {m1_q[i][35:0], 24'b0}
             + {m2_q[i][51:0], 8'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsp3_q <= bsp2_q;
      for (int i = 0; i < 4; i++) begin
        s_q[i]  <= s_d[i];
        m3_q[i] <= m3[i][WSUM_W-1:0];
      end
    end
  end

  // stage 4: finish the weight sum and drop the fraction
  logic [WSUM_W-1:0]  wsum [4];
  logic [WGT_W-1:0]   q4_q [4];
  logic               bsp4_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wsum[i] = s_q[i] + m3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsp4_q <= bsp3_q;
      for (int i = 0; i < 4; i++) begin
        q4_q[i] <= wsum[i][WSUM_W-1:32];
      end
    end
  end

  // stage 5: halve and scale by the reciprocal of three for the B-spline
  logic [31:0]        u [4];
  logic [63:0]        recip [4];
  logic [30:0]        r5_q [4];
  logic [WGT_W-1:0]   q5_q [4];
  logic               bsp5_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      u[i]     = {{5{q4_q[i][WGT_W-1]}}, q4_q[i][WGT_W-1:1]} + BSPL_OFS;
      recip[i] = u[i] * RECIP3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsp5_q <= bsp4_q;
      for (int i = 0; i < 4; i++) begin
        r5_q[i] <= recip[i][63:33];
        q5_q[i] <= q4_q[i];
      end
    end
  end

  // stage 6: remove the bias and select the weight
  logic [30:0]  r_adj [4];
  weight_t      w_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r_adj[i] = r5_q[i] - BSPL_BIAS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= bsp5_q ? $signed(r_adj[i][WGT_W-1:0]) : $signed(q5_q[i]);
      end
    end
  end

  assign weight_o = w_q;

endmodule

`default_nettype wire

// ----- src/ccse_dot.sv -----
// Four-stage pipeline that weights the control values, sums, rounds and saturates.
`default_nettype none

module ccse_dot import ccse_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  point_t   p_i [4],
  input  weight_t  weight_i [4],
  output point_t   value_o,
  output logic     saturated_o
);

  // delay the control values to meet their weights
  point_t p_dly_q [BASIS_LAT][4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        p_dly_q[0][i] <= p_i[i];
      end
      for (int j = 1; j < BASIS_LAT; j++) begin
        for (int i = 0; i < 4; i++) begin
          p_dly_q[j][i] <= p_dly_q[j-1][i];
        end
      end
    end
  end

  // stage 1: weight each control value
  logic signed [59:0] prod [4];
  logic signed [59:0] prod_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = p_dly_q[BASIS_LAT-1][i] * weight_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
    end
  end

  // stage 2: add in pairs
  logic signed [60:0] pair0_q;
  logic signed [60:0] pair1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair0_q <= {prod_q[0][59], prod_q[0]} + {prod_q[1][59], prod_q[1]};
      pair1_q <= {prod_q[2][59], prod_q[2]} + {prod_q[3][59], prod_q[3]};
    end
  end

  // stage 3: final sum with the half-step rounding offset
  localparam logic signed [61:0] HALF_Q20 = 62'sd524288;
  logic signed [61:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= {pair0_q[60], pair0_q} + {pair1_q[60], pair1_q} + HALF_Q20;
    end
  end

  // stage 4: drop the fraction and clamp to the output range
  logic [41:0]  v;
  logic         over;
  point_t       value_d;
  point_t       value_q;
  logic         sat_q;

  assign v    = acc_q[61:20];
  assign over = !((&v[41:31]) || !(|v[41:31]));

  always_comb begin
    if (over) begin
      value_d = v[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      value_d = $signed(v[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      sat_q   <= over;
    end
  end

  assign value_o     = value_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

// ----- src/cubic_curve_segment_evaluator_core.sv -----
// Top level of the cubic curve segment evaluator: handshake, tension register, pipeline.
`default_nettype none
`include "cubic_curve_segment_evaluator_core_assert.svh"

// Evaluates one coordinate of a linear, Catmull-Rom, uniform B-spline or cubic
// Bezier segment, or its first derivative in t, from four Q16.16 control values
// and t in Q1.16 (values above 1.0 act as 1.0). One transaction is taken every
// clock while the pipeline advances. Six stages form the basis weights
// (coefficient pick and t squared, t cubed, cubic term, weight sum, B-spline
// division by six, selection) and four apply them (multiply, pairwise add,
// final add with rounding, clamp). When the output holds a result that is
// stalled, the whole pipeline holds and in_stall_o rises. The Catmull-Rom
// tension (signed Q3.12) lies at APB byte address 0 and resets to 0.5; write
// it only while the block is empty.
module cubic_curve_segment_evaluator_core import ccse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic         derivative_i,
  input  logic [16:0]  t_frac_i,
  input  logic [31:0]  p0_i,
  input  logic [31:0]  p1_i,
  input  logic [31:0]  p2_i,
  input  logic [31:0]  p3_i,
  // output channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  value_o,
  output logic         saturated_o,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                   en;
  logic [PIPE_DEPTH-1:0]  valid_q;
  logic [15:0]            tension_q;
  point_t                 p_in [4];
  weight_t                weight [4];
  point_t                 value;

  // advance unless a finished result is held back
  assign en          = !(valid_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  // shift the valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // tension register write and read back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= TENSION_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tension_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {16'b0, tension_q};

  assign p_in[0] = p0_i;
  assign p_in[1] = p1_i;
  assign p_in[2] = p2_i;
  assign p_in[3] = p3_i;

  ccse_basis u_basis (
    .clk_i     (clk_i),
    .en_i      (en),
    .kind_i    (kind_e'(command_i)),
    .der_i     (derivative_i),
    .t_frac_i  (t_frac_i),
    .tension_i ($signed(tension_q)),
    .weight_o  (weight)
  );

  ccse_dot u_dot (
    .clk_i       (clk_i),
    .en_i        (en),
    .p_i         (p_in),
    .weight_i    (weight),
    .value_o     (value),
    .saturated_o (saturated_o)
  );

  assign value_o = value;

  `CCSE_ASSERT_IMP(a_sat_clamps, out_valid_o && saturated_o, value_o == 32'h7FFF_FFFF || value_o == 32'h8000_0000, "saturated result is not a range limit")
  `CCSE_ASSERT_NXT(a_stall_holds, out_valid_o && out_stall_i, $stable(valid_q) && $stable(value_o), "pipeline moved while output stalled")
  `CCSE_ASSERT_NXT(a_tension_wr, psel && penable && pwrite && !paddr[2], tension_q == $past(pwdata[15:0]), "tension write lost")

endmodule

`default_nettype wire
